/* rtl/core/bam_aux_field_validator_macros.svh */
// Assertion macros for the aux field validator.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef BAM_AUX_FIELD_VALIDATOR_MACROS_SVH
`define BAM_AUX_FIELD_VALIDATOR_MACROS_SVH

// generic clocked check with explicit clock and active-low reset
`define BAV_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// check on the block clock and reset
`define BAV_ASSERT(lbl, prop, msg) \
  `BAV_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* rtl/core/bav_pkg.sv */
// Shared types, codes and helpers for the aux field validator.
// No dependencies; used by the interfaces, the parser and the top level.
package bav_pkg;

  localparam int unsigned ITEM_COUNT_WIDTH_DEF = 16;
  localparam int unsigned OUT_COUNT_WIDTH      = 16;
  localparam int unsigned PENDING_WIDTH        = 34;

  localparam logic [7:0] CHAR_A_UP = 8'h41;
  localparam logic [7:0] CHAR_C_LO = 8'h63;
  localparam logic [7:0] CHAR_C_UP = 8'h43;
  localparam logic [7:0] CHAR_S_LO = 8'h73;
  localparam logic [7:0] CHAR_S_UP = 8'h53;
  localparam logic [7:0] CHAR_I_LO = 8'h69;
  localparam logic [7:0] CHAR_I_UP = 8'h49;
  localparam logic [7:0] CHAR_F_LO = 8'h66;
  localparam logic [7:0] CHAR_H_UP = 8'h48;
  localparam logic [7:0] CHAR_Z_UP = 8'h5A;
  localparam logic [7:0] CHAR_B_UP = 8'h42;
  localparam logic [7:0] CHAR_NUL  = 8'h00;

  typedef enum logic [2:0] {
    PH_TAG0,
    PH_TAG1,
    PH_TYPE,
    PH_DATA,
    PH_STRING,
    PH_SUBTYPE,
    PH_COUNT,
    PH_FAIL
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_TYPE,
    ERR_STRING,
    ERR_OVERRUN
  } err_e;

  typedef struct packed {
    logic [7:0] aux_byte;
    logic       last_of_record;
    logic       no_aux;
  } item_t;

  typedef struct packed {
    logic                         record_valid;
    err_e                         error_code;
    logic [OUT_COUNT_WIDTH-1:0]   item_count;
  } result_t;

  // value size in bytes for a scalar type code, 0 if not a scalar
  function automatic logic [2:0] scalar_size(input logic [7:0] c);
    logic [2:0] sz;
    case (c) inside
      CHAR_A_UP, CHAR_C_LO, CHAR_C_UP:  sz = 3'd1;
      CHAR_S_LO, CHAR_S_UP:             sz = 3'd2;
      CHAR_I_LO, CHAR_I_UP, CHAR_F_LO:  sz = 3'd4;
      default:                          sz = 3'd0;
    endcase
    return sz;
  endfunction

endpackage

/* rtl/core/bav_ifs.sv */
// Valid/ready channel interfaces for the aux field validator.
// Depends on bav_pkg for the result count width.
interface bav_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] aux_byte;
  logic       last_of_record;
  logic       no_aux;

  modport source (output valid, aux_byte, last_of_record, no_aux, input ready);
  modport sink   (input valid, aux_byte, last_of_record, no_aux, output ready);
endinterface

interface bav_out_if;
  logic                                valid;
  logic                                ready;
  logic                                record_valid;
  logic [1:0]                          error_code;
  logic [bav_pkg::OUT_COUNT_WIDTH-1:0] item_count;

  modport source (output valid, record_valid, error_code, item_count, input ready);
  modport sink   (input valid, record_valid, error_code, item_count, output ready);
endinterface

/* rtl/core/bav_parser.sv */
// Per-byte aux item walker: phase, pending byte count, array count, item count.
// Depends on bav_pkg and the assertion macro header.
`include "bam_aux_field_validator_macros.svh"

module bav_parser #(
  parameter int unsigned ITEM_COUNT_WIDTH = bav_pkg::ITEM_COUNT_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  bav_pkg::item_t   item_i,
  output logic             emit_o,
  output bav_pkg::result_t result_o
);

  localparam int unsigned PW = bav_pkg::PENDING_WIDTH;

  bav_pkg::phase_e             phase_q, phase_d;
  logic [PW-1:0]               pending_q, pending_d;
  logic [23:0]                 cnt_q, cnt_d;
  logic [1:0]                  idx_q, idx_d;
  logic [2:0]                  esize_q, esize_d;
  logic [ITEM_COUNT_WIDTH-1:0] items_q, items_d;

  logic [2:0]    sz;
  logic [PW-1:0] dec;
  logic [PW-1:0] prod;
  logic [31:0]   full_cnt;
  logic          fin;

  assign emit_o = item_i.last_of_record | item_i.no_aux;

  always_comb begin
    phase_d   = phase_q;
    pending_d = pending_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    esize_d   = esize_q;
    items_d   = items_q;
    fin       = 1'b0;
    sz        = bav_pkg::scalar_size(item_i.aux_byte);
    dec       = (pending_q == '0) ? '0 : pending_q - PW'(1);
    full_cnt  = {item_i.aux_byte, cnt_q};
    case (esize_q)
      3'd1:    prod = PW'(full_cnt);
      3'd2:    prod = PW'(full_cnt) << 1;
      3'd4:    prod = PW'(full_cnt) << 2;
      default: prod = '0;
    endcase
    unique case (phase_q)
      bav_pkg::PH_TAG0: phase_d = bav_pkg::PH_TAG1;
      bav_pkg::PH_TAG1: phase_d = bav_pkg::PH_TYPE;
      bav_pkg::PH_TYPE: begin
        if (sz != 3'd0) begin
          pending_d = PW'(sz);
          phase_d   = bav_pkg::PH_DATA;
        end else if (item_i.aux_byte == bav_pkg::CHAR_H_UP ||
                     item_i.aux_byte == bav_pkg::CHAR_Z_UP) begin
          phase_d = bav_pkg::PH_STRING;
        end else if (item_i.aux_byte == bav_pkg::CHAR_B_UP) begin
          phase_d = bav_pkg::PH_SUBTYPE;
        end else begin
          phase_d = bav_pkg::PH_FAIL;
        end
      end
      bav_pkg::PH_DATA: begin
        pending_d = dec;
        fin       = (dec == '0);
      end
      bav_pkg::PH_STRING: fin = (item_i.aux_byte == bav_pkg::CHAR_NUL);
      bav_pkg::PH_SUBTYPE: begin
        esize_d = (item_i.aux_byte == bav_pkg::CHAR_A_UP) ? 3'd0 : sz;
        cnt_d   = '0;
        idx_d   = '0;
        phase_d = bav_pkg::PH_COUNT;
      end
      bav_pkg::PH_COUNT: begin
        case (idx_q)
          2'd0:    cnt_d[7:0]   = item_i.aux_byte;
          2'd1:    cnt_d[15:8]  = item_i.aux_byte;
          2'd2:    cnt_d[23:16] = item_i.aux_byte;
          default: cnt_d        = cnt_q;
        endcase
        if (idx_q == 2'd3) begin
          idx_d = '0;
          if (prod == '0) begin
            fin = 1'b1;
          end else begin
            pending_d = prod;
            phase_d   = bav_pkg::PH_DATA;
          end
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      bav_pkg::PH_FAIL: phase_d = bav_pkg::PH_FAIL;
      default:          phase_d = bav_pkg::PH_FAIL;
    endcase
    if (fin) begin
      phase_d   = bav_pkg::PH_TAG0;
      pending_d = '0;
      items_d   = (items_q != '1) ? items_q + ITEM_COUNT_WIDTH'(1) : items_q;
    end
  end

  always_comb begin
    if (item_i.no_aux) begin
      result_o.record_valid = 1'b1;
      result_o.error_code   = bav_pkg::ERR_NONE;
      result_o.item_count   = '0;
    end else begin
      result_o.record_valid = (phase_d == bav_pkg::PH_TAG0);
      result_o.item_count   = bav_pkg::OUT_COUNT_WIDTH'(items_d);
      case (phase_d)
        bav_pkg::PH_TAG0:   result_o.error_code = bav_pkg::ERR_NONE;
        bav_pkg::PH_FAIL:   result_o.error_code = bav_pkg::ERR_TYPE;
        bav_pkg::PH_STRING: result_o.error_code = bav_pkg::ERR_STRING;
        default:            result_o.error_code = bav_pkg::ERR_OVERRUN;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bav_pkg::PH_TAG0;
      pending_q <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      esize_q   <= '0;
      items_q   <= '0;
    end else if (step_i) begin
      if (emit_o) begin
        phase_q   <= bav_pkg::PH_TAG0;
        pending_q <= '0;
        cnt_q     <= '0;
        idx_q     <= '0;
        esize_q   <= '0;
        items_q   <= '0;
      end else begin
        phase_q   <= phase_d;
        pending_q <= pending_d;
        cnt_q     <= cnt_d;
        idx_q     <= idx_d;
        esize_q   <= esize_d;
        items_q   <= items_d;
      end
    end
  end

  `BAV_ASSERT(a_pending_only_in_data,
    (phase_q == bav_pkg::PH_DATA) == (pending_q != '0),
    "pending byte count out of step with data phase")
  `BAV_ASSERT(a_idx_only_in_count,
    (idx_q != 2'd0) |-> (phase_q == bav_pkg::PH_COUNT),
    "count byte index set outside count phase")
  `BAV_ASSERT(a_clear_after_record,
    (step_i && emit_o) |=> (phase_q == bav_pkg::PH_TAG0 && items_q == '0),
    "state not cleared after record end")

endmodule

/* rtl/core/bam_aux_field_validator.sv */
// Top level of the aux field validator: input register, parser, result register.
// Depends on bav_pkg, bav_ifs, bav_parser and the assertion macro header.
//
//  channel | dir | payload                                 | item
//  in_i    | in  | aux_byte, last_of_record, no_aux        | one aux byte
//  out_o   | out | record_valid, error_code, item_count    | one per record
//
// One byte per cycle sustained unless a record-ending item waits on the result
// register; a record result passes the input register, then the result register.
// Reset clears the parser state and both valid flags; payload holds no meaning.
// A record-ending item waits in the input register while the result register
// is full and not taken; other bytes pass through regardless.
`include "bam_aux_field_validator_macros.svh"

module bam_aux_field_validator #(
  parameter int unsigned ITEM_COUNT_WIDTH = bav_pkg::ITEM_COUNT_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  bav_in_if.sink    in_i,
  bav_out_if.source out_o
);

  bav_pkg::item_t   s1_q;
  logic             s1_valid_q;
  bav_pkg::result_t out_q;
  logic             out_valid_q;

  bav_pkg::result_t res;
  logic             emit;
  logic             slot_free;
  logic             s1_fire;

  assign slot_free = !out_valid_q || out_o.ready;
  assign s1_fire   = s1_valid_q && (!emit || slot_free);
  assign in_i.ready = !s1_valid_q || s1_fire;

  bav_parser #(
    .ITEM_COUNT_WIDTH (ITEM_COUNT_WIDTH)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_fire),
    .item_i   (s1_q),
    .emit_o   (emit),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q.aux_byte       <= in_i.aux_byte;
      s1_q.last_of_record <= in_i.last_of_record;
      s1_q.no_aux         <= in_i.no_aux;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && emit) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.record_valid = out_q.record_valid;
  assign out_o.error_code   = out_q.error_code;
  assign out_o.item_count   = out_q.item_count;

  `BAV_ASSERT(a_stalled_item_held,
    (s1_valid_q && !s1_fire) |=> (s1_valid_q && $stable(s1_q)),
    "stalled item lost or changed in input register")
  `BAV_ASSERT(a_result_from_record_end,
    $rose(out_valid_q) |-> $past(s1_fire && emit),
    "result raised without a record-ending item")
  `BAV_ASSERT(a_valid_matches_code,
    out_valid_q |-> (out_q.record_valid == (out_q.error_code == bav_pkg::ERR_NONE)),
    "record_valid disagrees with error_code")

endmodule

/* verif/tb_bam_aux_field_validator.sv */
// Testbench for bam_aux_field_validator: a directed table with its own expected
// verdicts and random aux regions checked against an in-bench parser model.
// Depends on bav_pkg, bav_ifs and the block RTL.
module tb_bam_aux_field_validator;

  localparam int unsigned ICW         = bav_pkg::ITEM_COUNT_WIDTH_DEF;
  localparam int unsigned COUNT_MAX   = (32'd1 << ICW) - 1;
  localparam int          RAND_ITEMS  = 920;
  localparam int          HOLD_CYCLES = 120;

  typedef struct packed {
    logic          rec_ok;
    bav_pkg::err_e code;
    logic [15:0]   count;
  } verdict_t;

  typedef struct packed {
    logic [7:0] b;
    logic       lst;
    logic       na;
    logic       typed;
    verdict_t   v;
  } plan_row_t;

  localparam verdict_t NO_CHECK = '{1'b0, bav_pkg::ERR_NONE, 16'd0};

  localparam logic [7:0] SCALARS [8] = '{
    bav_pkg::CHAR_A_UP, bav_pkg::CHAR_C_LO, bav_pkg::CHAR_C_UP, bav_pkg::CHAR_S_LO,
    bav_pkg::CHAR_S_UP, bav_pkg::CHAR_I_LO, bav_pkg::CHAR_I_UP, bav_pkg::CHAR_F_LO
  };

  localparam plan_row_t PLAN [28] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, '{1'b1, bav_pkg::ERR_NONE, 16'd0}},
    '{8'h4E, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{8'h4D, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{bav_pkg::CHAR_C_LO, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{8'h80, 1'b1, 1'b0, 1'b1, '{1'b1, bav_pkg::ERR_NONE, 16'd1}},
    '{8'h58, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{8'h5A, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{bav_pkg::CHAR_Z_UP, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{bav_pkg::CHAR_NUL, 1'b1, 1'b0, 1'b1, '{1'b1, bav_pkg::ERR_NONE, 16'd1}},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{bav_pkg::CHAR_H_UP, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{8'hFF, 1'b1, 1'b0, 1'b1, '{1'b0, bav_pkg::ERR_STRING, 16'd0}},
    '{8'h71, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{8'h71, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{8'hFF, 1'b1, 1'b0, 1'b1, '{1'b0, bav_pkg::ERR_TYPE, 16'd0}},
    '{8'h74, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{8'h74, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{bav_pkg::CHAR_B_UP, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{bav_pkg::CHAR_A_UP, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{8'hFF, 1'b1, 1'b0, 1'b1, '{1'b1, bav_pkg::ERR_NONE, 16'd1}},
    '{8'h62, 1'b1, 1'b0, 1'b1, '{1'b0, bav_pkg::ERR_OVERRUN, 16'd0}},
    '{8'h41, 1'b0, 1'b0, 1'b0, NO_CHECK},
    '{8'hAA, 1'b1, 1'b1, 1'b1, '{1'b1, bav_pkg::ERR_NONE, 16'd0}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  bav_in_if  in_if ();
  bav_out_if out_if ();

  bam_aux_field_validator #(
    .ITEM_COUNT_WIDTH(ICW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // parser model state
  bav_pkg::phase_e ps_phase;
  logic [33:0]     ps_pending;
  logic [31:0]     ps_count;
  logic [1:0]      ps_idx;
  logic [2:0]      ps_esize;
  bav_pkg::err_e   ps_fail;
  int unsigned     ps_items;

  verdict_t    verdicts_due [$];
  logic [7:0]  rec_bytes [$];
  int          n_fail = 0;
  int          n_sent = 0;
  bit          no_gaps = 1'b0;
  bit          hold_req = 1'b0;
  int          tx_calm = 0;

  function automatic logic [2:0] value_bytes(input logic [7:0] c);
    if (c == bav_pkg::CHAR_A_UP || c == bav_pkg::CHAR_C_LO || c == bav_pkg::CHAR_C_UP)
      return 3'd1;
    if (c == bav_pkg::CHAR_S_LO || c == bav_pkg::CHAR_S_UP) return 3'd2;
    if (c == bav_pkg::CHAR_I_LO || c == bav_pkg::CHAR_I_UP || c == bav_pkg::CHAR_F_LO)
      return 3'd4;
    return 3'd0;
  endfunction

  function automatic void parse_clear();
    ps_phase   = bav_pkg::PH_TAG0;
    ps_pending = '0;
    ps_count   = '0;
    ps_idx     = '0;
    ps_esize   = '0;
    ps_fail    = bav_pkg::ERR_NONE;
    ps_items   = 0;
  endfunction

  function automatic void close_item();
    if (ps_items < COUNT_MAX) ps_items++;
    ps_phase   = bav_pkg::PH_TAG0;
    ps_pending = '0;
  endfunction

  function automatic void aux_parse_step(input logic [7:0] b, input logic lst,
                                         input logic na, output bit yields,
                                         output verdict_t v);
    v = NO_CHECK;
    yields = 1'b0;
    if (na) begin
      parse_clear();
      v = '{1'b1, bav_pkg::ERR_NONE, 16'd0};
      yields = 1'b1;
      return;
    end
    case (ps_phase)
      bav_pkg::PH_TAG0: ps_phase = bav_pkg::PH_TAG1;
      bav_pkg::PH_TAG1: ps_phase = bav_pkg::PH_TYPE;
      bav_pkg::PH_TYPE: begin
        if (value_bytes(b) != 3'd0) begin
          ps_pending = 34'(value_bytes(b));
          ps_phase   = bav_pkg::PH_DATA;
        end else if (b == bav_pkg::CHAR_H_UP || b == bav_pkg::CHAR_Z_UP) begin
          ps_phase = bav_pkg::PH_STRING;
        end else if (b == bav_pkg::CHAR_B_UP) begin
          ps_phase = bav_pkg::PH_SUBTYPE;
        end else begin
          ps_fail  = bav_pkg::ERR_TYPE;
          ps_phase = bav_pkg::PH_FAIL;
        end
      end
      bav_pkg::PH_DATA: begin
        if (ps_pending != '0) ps_pending--;
        if (ps_pending == '0) close_item();
      end
      bav_pkg::PH_STRING: begin
        if (b == bav_pkg::CHAR_NUL) close_item();
      end
      bav_pkg::PH_SUBTYPE: begin
        ps_esize = (b == bav_pkg::CHAR_A_UP) ? 3'd0 : value_bytes(b);
        ps_count = '0;
        ps_idx   = '0;
        ps_phase = bav_pkg::PH_COUNT;
      end
      bav_pkg::PH_COUNT: begin
        ps_count = ps_count | (32'(b) << (8 * ps_idx));
        if (ps_idx == 2'd3) begin
          ps_idx     = '0;
          ps_pending = 34'(ps_count) * 34'(ps_esize);
          if (ps_pending == '0) close_item();
          else ps_phase = bav_pkg::PH_DATA;
        end else begin
          ps_idx++;
        end
      end
      default: ;
    endcase
    if (!lst) return;
    yields = 1'b1;
    if (ps_fail != bav_pkg::ERR_NONE) v = '{1'b0, ps_fail, 16'(ps_items)};
    else if (ps_phase == bav_pkg::PH_TAG0) v = '{1'b1, bav_pkg::ERR_NONE, 16'(ps_items)};
    else if (ps_phase == bav_pkg::PH_STRING) v = '{1'b0, bav_pkg::ERR_STRING, 16'(ps_items)};
    else v = '{1'b0, bav_pkg::ERR_OVERRUN, 16'(ps_items)};
    parse_clear();
  endfunction

  function automatic int next_gap();
    int r;
    if (no_gaps) return 0;
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      tx_calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic drive(input logic [7:0] b, input logic lst, input logic na,
                       input logic typed, input verdict_t v);
    int gap;
    bit yields;
    verdict_t calc;
    gap = next_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.aux_byte       <= b;
    in_if.last_of_record <= lst;
    in_if.no_aux         <= na;
    do @(posedge clk_i); while (!in_if.ready);
    aux_parse_step(b, lst, na, yields, calc);
    if (typed) verdicts_due.push_back(v);
    else if (yields) verdicts_due.push_back(calc);
    n_sent++;
  endtask

  function automatic logic [7:0] pick_unknown_code();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (value_bytes(c) != 3'd0 || c == bav_pkg::CHAR_H_UP || c == bav_pkg::CHAR_Z_UP ||
           c == bav_pkg::CHAR_B_UP);
    return c;
  endfunction

  function automatic void put_random(input int n);
    repeat (n) rec_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_le32(input logic [31:0] n);
    for (int k = 0; k < 4; k++) rec_bytes.push_back(n[8*k +: 8]);
  endfunction

  function automatic void put_item();
    int k;
    logic [7:0] t;
    logic [31:0] n;
    logic [2:0] esz;
    put_random(2);
    k = $urandom_range(0, 9);
    if (k < 5) begin
      t = SCALARS[$urandom_range(0, 7)];
      rec_bytes.push_back(t);
      put_random(int'(value_bytes(t)));
    end else if (k < 7) begin
      rec_bytes.push_back(k == 5 ? bav_pkg::CHAR_H_UP : bav_pkg::CHAR_Z_UP);
      repeat ($urandom_range(0, 6)) rec_bytes.push_back(8'($urandom_range(1, 255)));
      rec_bytes.push_back(bav_pkg::CHAR_NUL);
    end else begin
      rec_bytes.push_back(bav_pkg::CHAR_B_UP);
      t = ($urandom_range(0, 9) < 7) ? SCALARS[$urandom_range(0, 7)] : pick_unknown_code();
      rec_bytes.push_back(t);
      esz = (t == bav_pkg::CHAR_A_UP) ? 3'd0 : value_bytes(t);
      n = $urandom_range(0, 4);
      put_le32(n);
      put_random(int'(n * 32'(esz)));
    end
  endfunction

  task automatic send_record(input bit abort);
    for (int k = 0; k < rec_bytes.size(); k++)
      drive(rec_bytes[k], (k == rec_bytes.size() - 1) && !abort, 1'b0, 1'b0, NO_CHECK);
    if (abort)
      drive(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 1'b0, NO_CHECK);
    rec_bytes.delete();
  endtask

  // result side: random stalls, calm stretches and requested long hold-offs
  initial begin
    int stall_left;
    int calm_left;
    int r;
    stall_left = 0;
    calm_left  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          calm_left = $urandom_range(50, 200);
          out_if.ready <= 1'b1;
        end else if (r < 70) begin
          out_if.ready <= 1'b1;
        end else if (r < 96) begin
          stall_left = $urandom_range(0, 2);
          out_if.ready <= 1'b0;
        end else begin
          stall_left = $urandom_range(10, 40);
          out_if.ready <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("result with no record pending");
        n_fail++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_if.record_valid !== want.rec_ok) begin
          $error("record_valid: expected %0b, got %0b", want.rec_ok, out_if.record_valid);
          n_fail++;
        end
        if (out_if.error_code !== want.code) begin
          $error("error_code: expected %0d, got %0d", want.code, out_if.error_code);
          n_fail++;
        end
        if (out_if.item_count !== want.count) begin
          $error("item_count: expected %0d, got %0d", want.count, out_if.item_count);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int rand_end;
    int kind;
    int cut;
    bit held_a;
    bit held_b;
    logic [31:0] big;
    held_a = 1'b0;
    held_b = 1'b0;
    rst_ni               <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.aux_byte       <= 8'h00;
    in_if.last_of_record <= 1'b0;
    in_if.no_aux         <= 1'b0;
    parse_clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (PLAN[k])
      drive(PLAN[k].b, PLAN[k].lst, PLAN[k].na, PLAN[k].typed, PLAN[k].v);

    rand_end = n_sent + RAND_ITEMS;
    while (n_sent < rand_end) begin
      if ((!held_a && n_sent >= rand_end - 650) || (!held_b && n_sent >= rand_end - 300)) begin
        if (held_a) held_b = 1'b1;
        held_a = 1'b1;
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        repeat (12) drive(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, NO_CHECK);
        no_gaps  = 1'b0;
      end
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        repeat ($urandom_range(1, 5)) put_item();
        send_record(1'b0);
      end else if (kind < 65) begin
        repeat ($urandom_range(1, 3)) put_item();
        cut = $urandom_range(1, rec_bytes.size() - 1);
        while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
        send_record(1'b0);
      end else if (kind < 72) begin
        // huge element count, region ends long before the elements do
        put_random(2);
        rec_bytes.push_back(bav_pkg::CHAR_B_UP);
        rec_bytes.push_back(SCALARS[$urandom_range(1, 7)]);
        big = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
        put_le32(big);
        put_random($urandom_range(0, 6));
        cut = $urandom_range(1, rec_bytes.size());
        while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
        send_record(1'b0);
      end else if (kind < 80) begin
        repeat ($urandom_range(0, 2)) put_item();
        put_random(2);
        rec_bytes.push_back(pick_unknown_code());
        put_random($urandom_range(0, 5));
        send_record(1'b0);
      end else if (kind < 88) begin
        drive(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 1'b0, NO_CHECK);
      end else if (kind < 93) begin
        put_random($urandom_range(1, 12));
        send_record(1'b0);
      end else begin
        repeat ($urandom_range(1, 2)) put_item();
        cut = $urandom_range(0, rec_bytes.size());
        while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
        send_record(1'b1);
      end
    end
    in_if.valid <= 1'b0;

    wait (verdicts_due.size() == 0);
    repeat (10) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
